// ----- hdl/ssm_pkg.sv -----
// Shared widths, request and status codes, and control structs of the sorted set block.
package ssm_pkg;

  localparam int unsigned REQ_W    = 2;
  localparam int unsigned CODE_W   = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned HELD_W   = 11;
  // Number of cell match flags folded into one group flag, and group flags per scan step
  localparam int unsigned GROUP_W  = 32;

  // Request types
  localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_QUERY = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_LOADED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DROPPED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FOUND   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_MISSING = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd4;

  // Broadcast to every cell of the row
  typedef struct packed {
    logic              load;
    logic [CODE_W-1:0] key;
  } cell_ctrl_t;

  // Control of the match flag reduction
  typedef struct packed {
    logic capture;
    logic shift;
  } red_ctrl_t;

endpackage

// ----- hdl/ssm_if.sv -----
// Request and response channel interfaces of the sorted set block.
interface ssm_req_if;
  logic                                valid;
  logic                                ready;
  logic        [ssm_pkg::REQ_W-1:0]    req_type;
  logic signed [ssm_pkg::CODE_W-1:0]   code;

  modport source (output valid, output req_type, output code, input ready);
  modport sink   (input valid, input req_type, input code, output ready);
endinterface

interface ssm_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [ssm_pkg::STATUS_W-1:0]  status;
  logic [ssm_pkg::HELD_W-1:0]    entries_held;

  modport source (output valid, output status, output entries_held, input ready);
  modport sink   (input valid, input status, input entries_held, output ready);
endinterface

// ----- hdl/sorted_set_membership.sv -----
// A load, clear or reserved request is registered on acceptance, then decoded in the execute
// state, and its result is registered in the respond state. A query goes from the execute state
// through the scan of group match flags, 32 per cycle, to the respond state. The next request is
// taken once the block is back in the idle state. One request is in flight at a time, and the
// respond state waits while the output stalls. Reset clears the count, the control state and
// the output valid; cell contents are not cleared, cells past the count are empty.
module sorted_set_membership #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ssm_req_if.sink     req_i,
  ssm_rsp_if.source   rsp_o
);

  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned G      = ssm_pkg::GROUP_W;
  localparam int unsigned NGRP   = (CAPACITY + G - 1) / G;
  localparam int unsigned NSTEP  = (NGRP + G - 1) / G;
  localparam int unsigned STEP_W = (NSTEP > 1) ? $clog2(NSTEP) : 1;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NSTEP - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(CAPACITY);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_SCAN, S_RESP} state_e;

  state_e                         state_q, state_d;
  logic [CNT_W-1:0]               count_q, count_d;
  logic [ssm_pkg::REQ_W-1:0]      req_q, req_d;
  logic [ssm_pkg::CODE_W-1:0]     key_q, key_d;
  logic [ssm_pkg::STATUS_W-1:0]   status_q, status_d;
  logic [STEP_W-1:0]              step_q, step_d;
  logic                           out_valid_q, out_valid_d;
  logic [ssm_pkg::STATUS_W-1:0]   out_status_q, out_status_d;
  logic [ssm_pkg::HELD_W-1:0]     out_held_q, out_held_d;

  ssm_pkg::cell_ctrl_t            cell_ctrl;
  ssm_pkg::red_ctrl_t             red_ctrl;
  logic [ssm_pkg::CODE_W-1:0]     cell_val [CAPACITY];
  logic [CAPACITY-1:0]            cell_gt;
  logic [CAPACITY-1:0]            cell_occ;
  logic [CAPACITY-1:0]            cell_match;
  logic                           found;

  // Occupancy of each cell follows from the count
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_occ[i] = CNT_W'(i) < count_q;
    end
  end

  // Row of cells, each fed by its left neighbor, the head cell by the key
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_head
      ssm_cell u_cell (
        .clk_i      (clk_i),
        .ctrl_i     (cell_ctrl),
        .occ_i      (cell_occ[i]),
        .left_val_i (key_q),
        .left_gt_i  (1'b0),
        .val_o      (cell_val[i]),
        .gt_o       (cell_gt[i]),
        .match_o    (cell_match[i])
      );
    end else begin : g_body
      ssm_cell u_cell (
        .clk_i      (clk_i),
        .ctrl_i     (cell_ctrl),
        .occ_i      (cell_occ[i]),
        .left_val_i (cell_val[i-1]),
        .left_gt_i  (cell_gt[i-1]),
        .val_o      (cell_val[i]),
        .gt_o       (cell_gt[i]),
        .match_o    (cell_match[i])
      );
    end
  end

  ssm_match_tree #(
    .Capacity (CAPACITY)
  ) u_match_tree (
    .clk_i   (clk_i),
    .ctrl_i  (red_ctrl),
    .match_i (cell_match),
    .found_o (found)
  );

  assign req_i.ready        = (state_q == S_IDLE);
  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = out_status_q;
  assign rsp_o.entries_held = out_held_q;

  // Sequence one request: decode, optional scan, then register the result
  always_comb begin
    state_d          = state_q;
    count_d          = count_q;
    req_d            = req_q;
    key_d            = key_q;
    status_d         = status_q;
    step_d           = step_q;
    out_valid_d      = out_valid_q;
    out_status_d     = out_status_q;
    out_held_d       = out_held_q;
    cell_ctrl.key    = key_q;
    cell_ctrl.load   = 1'b0;
    red_ctrl.capture = 1'b0;
    red_ctrl.shift   = 1'b0;

    // Drop the result once its transaction completes
    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          req_d   = req_i.req_type;
          key_d   = req_i.code;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_RESP;
        case (req_q)
          ssm_pkg::REQ_LOAD: begin
            if (count_q == FULL_CNT) begin
              status_d = ssm_pkg::ST_DROPPED;
            end else begin
              cell_ctrl.load = 1'b1;
              count_d        = count_q + 1'b1;
              status_d       = ssm_pkg::ST_LOADED;
            end
          end
          ssm_pkg::REQ_QUERY: begin
            red_ctrl.capture = 1'b1;
            step_d           = '0;
            state_d          = S_SCAN;
          end
          ssm_pkg::REQ_CLEAR: begin
            count_d  = '0;
            status_d = ssm_pkg::ST_CLEARED;
          end
          default: begin
            status_d = ssm_pkg::ST_MISSING;
          end
        endcase
      end
      S_SCAN: begin
        red_ctrl.shift = 1'b1;
        if (step_q == LAST_STEP) begin
          state_d = S_RESP;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      S_RESP: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d = 1'b1;
          if (req_q == ssm_pkg::REQ_QUERY) begin
            out_status_d = found ? ssm_pkg::ST_FOUND : ssm_pkg::ST_MISSING;
          end else begin
            out_status_d = status_q;
          end
          out_held_d = ssm_pkg::HELD_W'(count_q);
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold state, count and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      req_q        <= '0;
      key_q        <= '0;
      status_q     <= '0;
      step_q       <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= '0;
      out_held_q   <= '0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      req_q        <= req_d;
      key_q        <= key_d;
      status_q     <= status_d;
      step_q       <= step_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_held_q   <= out_held_d;
    end
  end

endmodule

// ----- hdl/ssm_cell.sv -----
// One cell of the sorted row: holds a code, shifts right on an ordered insert, flags a match.
module ssm_cell (
  input  logic                        clk_i,
  input  ssm_pkg::cell_ctrl_t         ctrl_i,
  input  logic                        occ_i,
  input  logic [ssm_pkg::CODE_W-1:0]  left_val_i,
  input  logic                        left_gt_i,
  output logic [ssm_pkg::CODE_W-1:0]  val_o,
  output logic                        gt_o,
  output logic                        match_o
);

  logic [ssm_pkg::CODE_W-1:0] val_q;

  // An empty cell counts as greater than any key, so the first free cell takes an append
  assign gt_o    = !occ_i || ($signed(val_q) > $signed(ctrl_i.key));
  assign match_o = occ_i && (val_q == ctrl_i.key);
  assign val_o   = val_q;

  // Insert: the boundary cell takes the key, cells past it take their left neighbor
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load && gt_o) begin
      val_q <= left_gt_i ? left_val_i : ctrl_i.key;
    end
  end

endmodule

// ----- hdl/ssm_match_tree.sv -----
// Registered reduction of the per-cell match flags: group OR, then a shifting scan.
module ssm_match_tree #(
  parameter int unsigned Capacity = 1024
) (
  input  logic                 clk_i,
  input  ssm_pkg::red_ctrl_t   ctrl_i,
  input  logic [Capacity-1:0]  match_i,
  output logic                 found_o
);

  localparam int unsigned G      = ssm_pkg::GROUP_W;
  localparam int unsigned NGRP   = (Capacity + G - 1) / G;
  localparam int unsigned NSTEP  = (NGRP + G - 1) / G;
  localparam int unsigned PAD_W  = NGRP * G;
  localparam int unsigned FLAG_W = NSTEP * G;

  logic [PAD_W-1:0]  match_pad;
  logic [FLAG_W-1:0] flags_d;
  logic [FLAG_W-1:0] flags_q;
  logic              acc_q;

  assign match_pad = PAD_W'(match_i);

  // Fold each group of cell flags into one bit
  always_comb begin
    flags_d = '0;
    for (int g = 0; g < NGRP; g++) begin
      flags_d[g] = |match_pad[g*G +: G];
    end
  end

  // Capture group flags, then fold one slice per shift step into the accumulator
  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      flags_q <= flags_d;
      acc_q   <= 1'b0;
    end else if (ctrl_i.shift) begin
      flags_q <= flags_q >> G;
      acc_q   <= acc_q | (|flags_q[G-1:0]);
    end
  end

  assign found_o = acc_q;

endmodule

// ----- hdl/ssm_checker.sv -----
// Port-level checks of the sorted set block and their bind to the top level.
module ssm_checker #(
  parameter int unsigned Capacity = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         rsp_valid_i,
  input  logic                         rsp_ready_i,
  input  logic [ssm_pkg::STATUS_W-1:0] rsp_status_i,
  input  logic [ssm_pkg::HELD_W-1:0]   rsp_held_i
);

  localparam logic [ssm_pkg::HELD_W-1:0] FULL_HELD = ssm_pkg::HELD_W'(Capacity);

  // Hold a stalled response transaction
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i) && $stable(rsp_held_i))
    else $error("response changed while stalled");

  // Status codes stay within the defined set
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> rsp_status_i <= ssm_pkg::ST_CLEARED)
    else $error("undefined status code");

  // A clear leaves the catalog empty
  a_clear_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i == ssm_pkg::ST_CLEARED |-> rsp_held_i == '0)
    else $error("clear reported a nonzero count");

  // A dropped load only happens on a full catalog
  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i == ssm_pkg::ST_DROPPED |-> rsp_held_i == FULL_HELD)
    else $error("load dropped below capacity");

  // A successful load leaves at least one entry held
  a_load_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i == ssm_pkg::ST_LOADED |-> rsp_held_i != '0)
    else $error("load reported an empty catalog");

endmodule

bind sorted_set_membership ssm_checker #(
  .Capacity (CAPACITY)
) u_ssm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status),
  .rsp_held_i   (rsp_o.entries_held)
);
